### hw/rtl/wmid_pkg.sv
// ----------------------------------------------------------------------------
// wmid_pkg
// Shared types and constants for the windowed motion interval detector.
// ----------------------------------------------------------------------------
`default_nettype none

package wmid_pkg;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TARGET_ID     = 2'd0,
      CSR_WINDOW_LENGTH = 2'd1,
      CSR_SPEED_LIMIT   = 2'd2
   } csr_index_type;

   localparam logic [31:0] RESET_WINDOW_LENGTH = 32'd1000000;
   localparam logic [31:0] RESET_SPEED_LIMIT   = 32'd65536;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PUSH,
      ST_PRUNE,
      ST_MUL,
      ST_FIN
   } state_type;

   // multiply sequence steps
   localparam logic [3:0] STEP_DX     = 4'd0;
   localparam logic [3:0] STEP_DY     = 4'd1;
   localparam logic [3:0] STEP_DZ     = 4'd2;
   localparam logic [3:0] STEP_P      = 4'd3;
   localparam logic [3:0] STEP_PLOAD  = 4'd4;
   localparam logic [3:0] STEP_PLL    = 4'd5;
   localparam logic [3:0] STEP_PLH    = 4'd6;
   localparam logic [3:0] STEP_PHH    = 4'd7;
   localparam logic [3:0] STEP_LAST   = 4'd8;
   localparam logic [3:0] STEP_CMP    = 4'd9;

   typedef struct packed {
      logic        pop;
      logic        push;
      logic        set_flag;
      logic [31:0] new_time;
   } cell_ctrl_type;

endpackage

`default_nettype wire

### hw/rtl/wmid_if.sv
// ----------------------------------------------------------------------------
// wmid_req_if / wmid_rsp_if
// Valid/ready channels carrying sample and interval words.
// ----------------------------------------------------------------------------
`default_nettype none

interface wmid_req_if;
   logic               valid;
   logic               ready;
   logic        [15:0] object_id;
   logic        [31:0] sample_time;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;

   modport source (output valid, object_id, sample_time, pos_x, pos_y, pos_z,
                   input ready);
   modport sink   (input valid, object_id, sample_time, pos_x, pos_y, pos_z,
                   output ready);
endinterface

interface wmid_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] interval_start;
   logic [31:0] interval_end;
   logic        extends_last;

   modport source (output valid, interval_start, interval_end, extends_last,
                   input ready);
   modport sink   (input valid, interval_start, interval_end, extends_last,
                   output ready);
endinterface

`default_nettype wire

### hw/rtl/windowed_motion_interval_detector_top.sv
// ----------------------------------------------------------------------------
// windowed_motion_interval_detector_top
// Time window of samples for one object, speed test, interval output.
// ----------------------------------------------------------------------------
// channel | dir | word
// req     | in  | object_id, sample_time, pos_x, pos_y, pos_z
// rsp     | out | interval_start, interval_end, extends_last
// csr     | in  | csr_we, csr_index, csr_wdata
//
// Other-id word: dropped at the push step. Matching word: push (a pop first if
// the window is full), prune, the steps on the shared 32x32 multiplier if more
// than two entries, then finish. Pruning pops one window cell per cycle.
// Reset is synchronous and clears control state only; no clearing pass.
// A waiting rsp word stalls only the finish step of the next word.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_motion_interval_detector_top #(
   parameter int unsigned WINDOW_DEPTH = 64
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   wmid_req_if.sink                               req_chan,
   wmid_rsp_if.source                             rsp_chan,
   input  wire logic                              csr_we,
   input  wire logic [wmid_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [wmid_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int unsigned FILL_W = $clog2(WINDOW_DEPTH + 1);
   localparam logic [FILL_W-1:0] FULL  = FILL_W'(WINDOW_DEPTH);
   localparam logic [FILL_W-1:0] ONE   = FILL_W'(1);
   localparam logic [FILL_W-1:0] TWO   = FILL_W'(2);

   logic [15:0] target_id_ff;
   logic [31:0] window_length_ff, speed_limit_ff;

   wmid_pkg::state_type state_ff, state_in;
   logic [3:0]  step_ff, step_in;

   logic [15:0] id_ff;
   logic [31:0] t_ff;
   logic signed [31:0] x_ff, y_ff, z_ff;
   logic signed [31:0] prev_x_ff, prev_y_ff, prev_z_ff;
   logic [31:0] prev_time_ff;
   logic [FILL_W-1:0] fill_ff, fill_in, mov_ff, mov_in;
   logic [31:0] last_end_ff;
   logic        have_ff;

   logic [63:0]  prod_ff;
   logic [65:0]  accd_ff;
   logic [63:0]  p_ff;
   logic [127:0] accp_ff;
   logic         moving_ff;

   logic         rsp_valid_ff;
   logic [31:0]  rsp_start_ff, rsp_end_ff;
   logic         rsp_ext_ff;

   wmid_pkg::cell_ctrl_type ctrl;
   logic [31:0] cell_time [WINDOW_DEPTH];
   logic        cell_flag [WINDOW_DEPTH];
   logic [31:0] head_time;
   logic        head_flag;

   logic req_fire, out_free, prune_hit, fin_go;
   logic [FILL_W-1:0] mov_dec, mov_fin;
   logic [31:0] mul_a, mul_b;
   logic [31:0] dx, dy, dz, dt;
   logic signed [32:0] sx, sy, sz;

   assign head_time = cell_time[0];
   assign head_flag = cell_flag[0];

   assign req_chan.ready = (state_ff == wmid_pkg::ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_id_ff     <= '0;
         window_length_ff <= wmid_pkg::RESET_WINDOW_LENGTH;
         speed_limit_ff   <= wmid_pkg::RESET_SPEED_LIMIT;
      end else if (csr_we) begin
         unique case (wmid_pkg::csr_index_type'(csr_index))
            wmid_pkg::CSR_TARGET_ID:     target_id_ff     <= csr_wdata[15:0];
            wmid_pkg::CSR_WINDOW_LENGTH: window_length_ff <= csr_wdata;
            wmid_pkg::CSR_SPEED_LIMIT:   speed_limit_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // window chain
   for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
      logic [31:0] rt;
      logic        rf;
      if (i == WINDOW_DEPTH - 1) begin : g_end
         assign rt = '0;
         assign rf = 1'b0;
      end else begin : g_mid
         assign rt = cell_time[i+1];
         assign rf = cell_flag[i+1];
      end
      wmid_cell #(.INDEX(i), .FILL_W(FILL_W)) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .fill       (fill_ff),
         .right_time (rt),
         .right_flag (rf),
         .time_q     (cell_time[i]),
         .flag_q     (cell_flag[i])
      );
   end

   assign prune_hit = (fill_ff != '0) && (t_ff >= head_time) &&
                      ((t_ff - head_time) > window_length_ff);
   assign mov_dec   = (head_flag && mov_ff != '0) ? mov_ff - ONE : mov_ff;
   assign mov_fin   = mov_ff + FILL_W'(moving_ff);
   assign fin_go    = (state_ff == wmid_pkg::ST_FIN) && out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         wmid_pkg::ST_IDLE:  if (req_fire) state_in = wmid_pkg::ST_PUSH;
         wmid_pkg::ST_PUSH: begin
            if (id_ff != target_id_ff) state_in = wmid_pkg::ST_IDLE;
            else if (fill_ff != FULL) state_in = wmid_pkg::ST_PRUNE;
         end
         wmid_pkg::ST_PRUNE: begin
            if (!prune_hit) begin
               step_in  = wmid_pkg::STEP_DX;
               state_in = (fill_ff > TWO) ? wmid_pkg::ST_MUL : wmid_pkg::ST_FIN;
            end
         end
         wmid_pkg::ST_MUL: begin
            step_in = step_ff + 4'd1;
            if (step_ff == wmid_pkg::STEP_CMP) state_in = wmid_pkg::ST_FIN;
         end
         wmid_pkg::ST_FIN:   if (out_free) state_in = wmid_pkg::ST_IDLE;
         default:            state_in = wmid_pkg::ST_IDLE;
      endcase
   end

   // window controls
   always_comb begin
      ctrl          = '0;
      ctrl.new_time = t_ff;
      fill_in       = fill_ff;
      mov_in        = mov_ff;
      unique case (state_ff)
         wmid_pkg::ST_PUSH: begin
            if (id_ff == target_id_ff) begin
               if (fill_ff == FULL) begin
                  ctrl.pop = 1'b1;
                  fill_in  = fill_ff - ONE;
                  mov_in   = mov_dec;
               end else begin
                  ctrl.push = 1'b1;
                  fill_in   = fill_ff + ONE;
               end
            end
         end
         wmid_pkg::ST_PRUNE: begin
            if (prune_hit) begin
               ctrl.pop = 1'b1;
               fill_in  = fill_ff - ONE;
               mov_in   = mov_dec;
            end
         end
         wmid_pkg::ST_FIN: begin
            if (out_free) begin
               ctrl.set_flag = moving_ff;
               mov_in        = mov_fin;
            end
         end
         default: ;
      endcase
   end

   // speed test operands
   assign sx = 33'(x_ff) - 33'(prev_x_ff);
   assign sy = 33'(y_ff) - 33'(prev_y_ff);
   assign sz = 33'(z_ff) - 33'(prev_z_ff);
   assign dx = sx[32] ? 32'(-sx) : sx[31:0];
   assign dy = sy[32] ? 32'(-sy) : sy[31:0];
   assign dz = sz[32] ? 32'(-sz) : sz[31:0];
   assign dt = (t_ff >= prev_time_ff) ? t_ff - prev_time_ff : prev_time_ff - t_ff;

   always_comb begin
      case (step_ff)
         wmid_pkg::STEP_DX:  begin mul_a = dx;           mul_b = dx;           end
         wmid_pkg::STEP_DY:  begin mul_a = dy;           mul_b = dy;           end
         wmid_pkg::STEP_DZ:  begin mul_a = dz;           mul_b = dz;           end
         wmid_pkg::STEP_P:   begin mul_a = speed_limit_ff; mul_b = dt;         end
         wmid_pkg::STEP_PLL: begin mul_a = p_ff[31:0];   mul_b = p_ff[31:0];   end
         wmid_pkg::STEP_PLH: begin mul_a = p_ff[31:0];   mul_b = p_ff[63:32];  end
         wmid_pkg::STEP_PHH: begin mul_a = p_ff[63:32];  mul_b = p_ff[63:32];  end
         default:            begin mul_a = '0;           mul_b = '0;           end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= 64'(mul_a) * 64'(mul_b);
      if (state_ff == wmid_pkg::ST_MUL) begin
         case (step_ff)
            wmid_pkg::STEP_DY:    accd_ff <= 66'(prod_ff);
            wmid_pkg::STEP_DZ,
            wmid_pkg::STEP_P:     accd_ff <= accd_ff + 66'(prod_ff);
            wmid_pkg::STEP_PLOAD: p_ff    <= prod_ff;
            wmid_pkg::STEP_PLH:   accp_ff <= 128'(prod_ff);
            wmid_pkg::STEP_PHH:   accp_ff <= accp_ff + (128'(prod_ff) << 33);
            wmid_pkg::STEP_LAST:  accp_ff <= accp_ff + (128'(prod_ff) << 64);
            wmid_pkg::STEP_CMP:   moving_ff <= {30'd0, accd_ff, 32'd0} > accp_ff;
            default: ;
         endcase
      end else if (state_ff == wmid_pkg::ST_PRUNE) begin
         moving_ff <= 1'b0;
      end
      if (req_fire) begin
         id_ff <= req_chan.object_id;
         t_ff  <= req_chan.sample_time;
         x_ff  <= req_chan.pos_x;
         y_ff  <= req_chan.pos_y;
         z_ff  <= req_chan.pos_z;
      end
      if (fin_go && mov_fin != '0) begin
         rsp_start_ff <= head_time;
         rsp_end_ff   <= t_ff;
         rsp_ext_ff   <= have_ff && (last_end_ff >= head_time);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wmid_pkg::ST_IDLE;
         step_ff      <= wmid_pkg::STEP_DX;
         fill_ff      <= '0;
         mov_ff       <= '0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         prev_z_ff    <= '0;
         prev_time_ff <= '0;
         last_end_ff  <= '0;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         fill_ff  <= fill_in;
         mov_ff   <= mov_in;
         rsp_valid_ff <= (fin_go && mov_fin != '0) || (rsp_valid_ff && !rsp_chan.ready);
         if (fin_go) begin
            prev_x_ff    <= x_ff;
            prev_y_ff    <= y_ff;
            prev_z_ff    <= z_ff;
            prev_time_ff <= t_ff;
            if (mov_fin != '0) begin
               last_end_ff  <= t_ff;
               have_ff      <= 1'b1;
            end
         end
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.interval_start = rsp_start_ff;
   assign rsp_chan.interval_end   = rsp_end_ff;
   assign rsp_chan.extends_last   = rsp_ext_ff;

endmodule

`default_nettype wire

### hw/rtl/wmid_cell.sv
// ----------------------------------------------------------------------------
// wmid_cell
// One window slot: holds a time and a moving flag, shifts toward the head.
// ----------------------------------------------------------------------------
`default_nettype none

module wmid_cell #(
   parameter int unsigned INDEX  = 0,
   parameter int unsigned FILL_W = 7
) (
   input  wire logic                   clock,
   input  wire wmid_pkg::cell_ctrl_type ctrl,
   input  wire logic [FILL_W-1:0]      fill,
   input  wire logic [31:0]            right_time,
   input  wire logic                   right_flag,
   output logic      [31:0]            time_q,
   output logic                        flag_q
);

   localparam logic [FILL_W-1:0] MY_INDEX   = FILL_W'(INDEX);
   localparam logic [FILL_W-1:0] TAIL_INDEX = FILL_W'(INDEX + 1);

   logic [31:0] time_ff, time_in;
   logic        flag_ff, flag_in;

   always_comb begin
      time_in = time_ff;
      flag_in = flag_ff;
      if (ctrl.pop) begin
         time_in = right_time;
         flag_in = right_flag;
      end else if (ctrl.push && fill == MY_INDEX) begin
         time_in = ctrl.new_time;
         flag_in = 1'b0;
      end else if (ctrl.set_flag && fill == TAIL_INDEX) begin
         flag_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      time_ff <= time_in;
      flag_ff <= flag_in;
   end

   assign time_q = time_ff;
   assign flag_q = flag_ff;

endmodule

`default_nettype wire

### hw/rtl/wmid_checker.sv
// ----------------------------------------------------------------------------
// wmid_checker
// Port-level checks for the detector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module wmid_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready
);

   // rsp word holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   // reset empties the output register
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid after reset");

   // one word in flight
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req ready right after accept");

endmodule

bind windowed_motion_interval_detector_top wmid_checker u_wmid_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready)
);

`default_nettype wire
